// ===== rtl/fpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsp_pkg
// Shared types and constants of the float to PCM sample packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsp_pkg;

	localparam int unsigned CfgIdxW  = 1;
	localparam int unsigned CfgDataW = 3;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_SAMPLE_FORMAT = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_LITTLE_ENDIAN = 1'd1;

	typedef enum logic [2:0] {
		FMT_INT8    = 3'd0,
		FMT_INT16   = 3'd1,
		FMT_INT24   = 3'd2,
		FMT_INT32   = 3'd3,
		FMT_FLOAT32 = 3'd4,
		FMT_FLOAT64 = 3'd5,
		FMT_RSVD6   = 3'd6,
		FMT_RSVD7   = 3'd7
	} fmt_t;

	typedef struct packed {
		logic [63:0] sample_bits;
		logic        end_of_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] packed_bytes;
		logic [3:0]  byte_count;
		logic        last_of_block;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/fpsp_scale.sv =====
// ----------------------------------------------------------------------------
// fpsp_scale
// Clamp an IEEE single to [-1,1], multiply by the format's full-scale value
// with round to nearest even, truncate toward zero. Result is a 32-bit signed
// integer, saturated at +2147483647.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsp_scale
	import fpsp_pkg::*;
(
	input  wire logic [31:0] single,
	input  fmt_t             fmt,
	output logic      [31:0] value
);

	// |x| < 1 after clamp: significand times K, exponent e in -126..-1
	logic        sign;
	logic [7:0]  expo;
	logic [22:0] frac;
	logic        is_nan;
	logic        is_big;
	logic        is_zero;
	logic [23:0] mant;
	logic [22:0] kval;
	logic [47:0] prod;
	logic [47:0] prodn;
	logic [5:0]  plen;
	logic [5:0]  drop;
	logic [24:0] rnd;
	logic        guard;
	logic        sticky;
	logic [47:0] lowmask;
	logic [47:0] tval;
	logic [31:0] i32;
	logic [31:0] mag;

	assign sign    = single[31];
	assign expo    = single[30:23];
	assign frac    = single[22:0];
	assign is_nan  = (expo == 8'hFF) && (frac != 23'd0);
	assign is_big  = (expo >= 8'd127);
	assign is_zero = (expo == 8'd0);
	assign mant    = {1'b1, frac};

	// full-scale constants; int32 scale is 2^31 in single precision
	always_comb begin
		case (fmt)
			FMT_INT8:  kval = 23'd127;
			FMT_INT16: kval = 23'd32767;
			FMT_INT24: kval = 23'd8388607;
			default:   kval = 23'd1;
		endcase
	end

	assign prod = {25'd0, kval} * {24'd0, mant};

	// find the length of the product
	always_comb begin
		plen = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (prod[i]) plen = 6'(i + 1);
		end
	end

	// round the product to 24 significant bits, nearest even
	assign drop    = (plen > 6'd24) ? plen - 6'd24 : 6'd0;
	assign lowmask = (48'd1 << drop) - 48'd1;
	assign guard   = (drop != 6'd0) ? prod[drop - 6'd1] : 1'b0;
	assign sticky  = (drop > 6'd1) ? ((prod & (lowmask >> 1)) != 48'd0) : 1'b0;
	assign rnd     = 25'(prod >> drop) +
		25'(guard && (sticky || prod[drop]));
	assign prodn   = 48'(rnd) << drop;

	// value = prodn * 2^(e - 150); e - 150 is negative, truncate by shift
	assign tval = prodn >> (8'd150 - expo);

	// int32: mant * 2^(e - 119) is exact, shift either way
	always_comb begin
		if (expo >= 8'd120) begin
			i32 = {8'd0, mant} << (expo - 8'd119);
		end else begin
			i32 = {8'd0, mant} >> (8'd119 - expo);
		end
	end

	// clamp and saturate
	always_comb begin
		if (is_nan || is_zero) begin
			mag = 32'd0;
		end else if (is_big) begin
			mag = (fmt == FMT_INT32) ? 32'h8000_0000 : {9'd0, kval};
		end else if (fmt == FMT_INT32) begin
			mag = i32;
		end else begin
			mag = tval[31:0];
		end
		if (is_nan || is_zero) begin
			value = 32'd0;
		end else if (!sign) begin
			value = (mag[31]) ? 32'h7FFF_FFFF : mag;
		end else begin
			value = ~mag + 32'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fpsp_pack.sv =====
// ----------------------------------------------------------------------------
// fpsp_pack
// Select the format's bytes, offset int8, and order them per byte order.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsp_pack
	import fpsp_pkg::*;
(
	input  wire logic [63:0] sample_bits,
	input  wire logic [31:0] ival,
	input  fmt_t             fmt,
	input  wire logic        le,
	output logic      [63:0] bytes_out,
	output logic      [3:0]  count
);

	logic [63:0] v;
	logic [7:0]  off8;

	// int8 value lies in -127..127, so the offset never clamps
	assign off8 = ival[7:0] + 8'd128;

	always_comb begin
		case (fmt)
			FMT_INT8:    begin v = {56'd0, off8};              count = 4'd1; end
			FMT_INT16:   begin v = {48'd0, ival[15:0]};        count = 4'd2; end
			FMT_INT24:   begin v = {40'd0, ival[23:0]};        count = 4'd3; end
			FMT_INT32:   begin v = {32'd0, ival};              count = 4'd4; end
			FMT_FLOAT32: begin v = {32'd0, sample_bits[31:0]}; count = 4'd4; end
			default:     begin v = sample_bits;                count = 4'd8; end
		endcase
	end

	// reverse the low count bytes for big endian
	always_comb begin
		bytes_out = v;
		if (!le) begin
			case (count)
				4'd2:    bytes_out = {48'd0, v[7:0], v[15:8]};
				4'd3:    bytes_out = {40'd0, v[7:0], v[15:8], v[23:16]};
				4'd4:    bytes_out = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
				4'd8:    bytes_out = {v[7:0], v[15:8], v[23:16], v[31:24],
					v[39:32], v[47:40], v[55:48], v[63:56]};
				default: bytes_out = v;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/float_to_pcm_sample_packer.sv =====
// ----------------------------------------------------------------------------
// float_to_pcm_sample_packer
// Converts one audio sample a beat into the bytes of the configured format.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | in_item_t  (sample, end of block)
//  out     | output    | out_valid/stall| out_item_t (bytes, count, last)
//  cfg     | input     | cfg_we         | cfg_index, cfg_data
//
//  One beat per cycle while out does not stall.
//  Input is registered in s1, result in s2; s1 advances whenever s2 is free
//  or being taken. A stall on out holds s2 and, when s1 is full, in.
//  Reset empties both stages and sets int16, little endian.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_pcm_sample_packer
	import fpsp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_item
);

	fmt_t      fmt_q;
	logic      le_q;
	logic      v_s1;
	in_item_t  d_s1;
	logic      v_s2;
	out_item_t d_s2;
	logic      adv2;
	logic      adv1;
	logic [31:0] ival;
	logic [63:0] pbytes;
	logic [3:0]  pcount;

	// write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_INT16;
			le_q  <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_SAMPLE_FORMAT) fmt_q <= fmt_t'(cfg_data);
			if (cfg_index == REG_LITTLE_ENDIAN) le_q  <= cfg_data[0];
		end
	end

	assign adv2     = !v_s2 || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) d_s1 <= in_item;
	end

	fpsp_scale u_scale (
		.single (d_s1.sample_bits[31:0]),
		.fmt    (fmt_q),
		.value  (ival)
	);

	fpsp_pack u_pack (
		.sample_bits (d_s1.sample_bits),
		.ival        (ival),
		.fmt         (fmt_q),
		.le          (le_q),
		.bytes_out   (pbytes),
		.count       (pcount)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) d_s2 <= '{pbytes, pcount, d_s1.end_of_block};
	end

	assign out_valid = v_s2;
	assign out_item  = d_s2;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_stall |=> v_s2 && $stable(d_s2)) else $error("result lost");
	// input is only stalled when both stages are full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2) else $error("needless stall");
	// count is always a legal size
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (d_s2.byte_count == 4'd1 || d_s2.byte_count == 4'd2 ||
		d_s2.byte_count == 4'd3 || d_s2.byte_count == 4'd4 ||
		d_s2.byte_count == 4'd8)) else $error("bad count");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the float to PCM sample packer. A directed table
// covers full scale, infinities, NaN, denormals, pass-through and byte order
// for every format; random samples follow in four phases of input idling and output stalls. Every
// result beat is checked against its table row or a bit-exact single-precision model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
	import fpsp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_item;

	float_to_pcm_sample_packer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// predictor copy of the registers
	fmt_t        cur_fmt;
	logic        cur_le;
	out_item_t   pending_beats[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned idle_pct;
	int unsigned stall_pct;

	typedef struct {
		fmt_t        fmt;
		logic        le;
		logic [63:0] bits;
		logic        eob;
		logic        known;
		logic [63:0] bytes;
		logic [3:0]  count;
	} vec_t;

	vec_t vecs[$];

	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	// Clamp, scale by km*2^ke with round to nearest even, truncate to integer.
	function automatic longint scale_to_int(logic [31:0] b, longint km, int ke);
		logic [7:0] ex;
		longint     m, p, q, rem, half, mag;
		int         e, s, t, nbits;
		ex = b[30:23];
		if (ex == 8'hFF && b[22:0] != 0)
			return 0;
		if (ex >= 127) begin
			mag = km <<< ke;
		end else begin
			if (ex == 0) begin
				m = b[22:0];
				e = -149;
			end else begin
				m = {1'b1, b[22:0]};
				e = int'(ex) - 150;
			end
			p = m * km;
			nbits = 0;
			for (int i = 0; i < 63; i++)
				if (p[i])
					nbits = i + 1;
			s = (nbits > 24) ? nbits - 24 : 0;
			q = p >>> s;
			if (s > 0) begin
				rem  = p & ((64'sd1 <<< s) - 1);
				half = 64'sd1 <<< (s - 1);
				if (rem > half || (rem == half && q[0]))
					q++;
			end
			t = e + ke + s;
			if (t >= 0)
				mag = q <<< t;
			else if (-t >= 63)
				mag = 0;
			else
				mag = q >>> (-t);
		end
		if (!b[31] && mag >= (64'sd1 <<< 31))
			return 64'sd2147483647;
		return b[31] ? -mag : mag;
	endfunction

	function automatic out_item_t pack_sample(fmt_t fmt, logic le, logic [63:0] bits,
			logic eob);
		out_item_t   r;
		logic [63:0] v;
		longint      sv;
		int          n;
		case (fmt)
			FMT_INT8: begin
				sv = scale_to_int(bits[31:0], 127, 0) + 128;
				if (sv < 0)
					sv = 0;
				if (sv > 255)
					sv = 255;
				v = sv;
				n = 1;
			end
			FMT_INT16: begin
				v = scale_to_int(bits[31:0], 32767, 0);
				n = 2;
			end
			FMT_INT24: begin
				v = scale_to_int(bits[31:0], 8388607, 0);
				n = 3;
			end
			FMT_INT32: begin
				v = scale_to_int(bits[31:0], 1, 31);
				n = 4;
			end
			FMT_FLOAT32: begin
				v = {32'd0, bits[31:0]};
				n = 4;
			end
			default: begin
				v = bits;
				n = 8;
			end
		endcase
		if (n < 8)
			v &= (64'd1 << (8 * n)) - 1;
		r.packed_bytes = v;
		if (!le) begin
			r.packed_bytes = '0;
			for (int i = 0; i < n; i++)
				r.packed_bytes[8*i +: 8] = v[8*(n-1-i) +: 8];
		end
		r.byte_count    = 4'(n);
		r.last_of_block = eob;
		return r;
	endfunction

	// wait until every beat is back, then let the pipe settle
	task automatic drain();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// drive one register write; the caller drops the write enable
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == REG_SAMPLE_FORMAT)
			cur_fmt = fmt_t'(data);
		else
			cur_le = data[0];
	endtask

	task automatic set_format(fmt_t fmt, logic le);
		drain();
		// upper data bits are don't-care for the endian register
		write_reg(REG_SAMPLE_FORMAT, fmt);
		write_reg(REG_LITTLE_ENDIAN, {(CfgDataW-1)'($urandom), le});
		cfg_we <= 1'b0;
	endtask

	// present one beat, hold it until taken, then maybe idle
	task automatic send_beat(logic [63:0] bits, logic eob, logic known,
			out_item_t typed);
		in_valid <= 1'b1;
		in_item  <= '{sample_bits: bits, end_of_block: eob};
		pending_beats.push_back(known ? typed : pack_sample(cur_fmt, cur_le, bits, eob));
		do
			@(posedge clk);
		while (in_stall);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	function automatic logic [63:0] random_sample();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1: ;
			2: r[30:0] = {8'($urandom_range(255, 127)), 23'($urandom)};
			3: begin
				case ($urandom_range(5))
					0: r[31:0] = 32'h7FC00000 | 32'($urandom_range(1));
					1: r[31:0] = 32'h7F800000;
					2: r[31:0] = 32'hFF800000;
					3: r[31:0] = 32'h3F800000;
					4: r[31:0] = 32'hBF800000;
					default: r[30:0] = 31'($urandom_range(255));
				endcase
			end
			default: r[30:0] = {8'($urandom_range(126, 100)), 23'($urandom)};
		endcase
		return r;
	endfunction

	function automatic vec_t vrow(fmt_t f, int le, logic [63:0] b, int eob,
			int k, logic [63:0] by, int c);
		vec_t v;
		v = '{fmt: f, le: 1'(le), bits: b, eob: 1'(eob), known: 1'(k), bytes: by,
			count: 4'(c)};
		return v;
	endfunction

	// check result beats against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat %h", out_item);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (out_item.packed_bytes !== want.packed_bytes) begin
					$error("packed_bytes exp %h got %h", want.packed_bytes,
						out_item.packed_bytes);
					errors++;
				end
				if (out_item.byte_count !== want.byte_count) begin
					$error("byte_count exp %0d got %0d", want.byte_count,
						out_item.byte_count);
					errors++;
				end
				if (out_item.last_of_block !== want.last_of_block) begin
					$error("last_of_block exp %0d got %0d", want.last_of_block,
						out_item.last_of_block);
					errors++;
				end
			end
		end
	end

	// random receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// run timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		out_item_t typed;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_stall = 1'b0;
		errors    = 0;
		cycles    = 0;
		idle_pct  = 0;
		stall_pct = 0;
		cur_fmt   = FMT_INT16;
		cur_le    = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full scale, specials and byte order per format
		vecs.push_back(vrow(FMT_INT16, 1, 64'hFFFF0000_3F800000, 0, 1, 64'h7FFF, 2));
		vecs.push_back(vrow(FMT_INT16, 1, 64'h00000000_BF800000, 1, 1, 64'h8001, 2));
		vecs.push_back(vrow(FMT_INT16, 1, 64'h12345678_7FC00000, 0, 1, 64'h0, 2));
		vecs.push_back(vrow(FMT_INT16, 1, 64'h0_7F800000, 0, 1, 64'h7FFF, 2));
		vecs.push_back(vrow(FMT_INT16, 1, 64'h0_FF800000, 1, 1, 64'h8001, 2));
		vecs.push_back(vrow(FMT_INT16, 1, 64'h0_3E2AAAAB, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_INT16, 0, 64'h0_3F800000, 0, 1, 64'hFF7F, 2));
		vecs.push_back(vrow(FMT_INT16, 0, 64'h0_BF000001, 1, 0, 0, 0));
		vecs.push_back(vrow(FMT_INT8, 1, 64'h0_3F800000, 0, 1, 64'hFF, 1));
		vecs.push_back(vrow(FMT_INT8, 1, 64'h0_BF800000, 0, 1, 64'h01, 1));
		vecs.push_back(vrow(FMT_INT8, 1, 64'h0_FFC00000, 1, 1, 64'h80, 1));
		vecs.push_back(vrow(FMT_INT8, 0, 64'h0_BF000000, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_INT24, 1, 64'h0_3F800000, 0, 1, 64'h7FFFFF, 3));
		vecs.push_back(vrow(FMT_INT24, 1, 64'h0_BF800000, 1, 1, 64'h800001, 3));
		vecs.push_back(vrow(FMT_INT24, 0, 64'h0_3F7FFFFF, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_INT32, 1, 64'h0_3F800000, 0, 1, 64'h7FFFFFFF, 4));
		vecs.push_back(vrow(FMT_INT32, 1, 64'h0_BF800000, 1, 1, 64'h80000000, 4));
		vecs.push_back(vrow(FMT_INT32, 0, 64'h0_3F7FFFFF, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_INT32, 0, 64'h0_80000001, 1, 0, 0, 0));
		vecs.push_back(vrow(FMT_FLOAT32, 1, 64'hFFFFFFFF_12345678, 0, 1,
			64'h12345678, 4));
		vecs.push_back(vrow(FMT_FLOAT32, 0, 64'h0_FFFFFFFF, 1, 0, 0, 0));
		vecs.push_back(vrow(FMT_FLOAT64, 1, 64'hFFFFFFFF_FFFFFFFF, 1, 1,
			64'hFFFFFFFF_FFFFFFFF, 8));
		vecs.push_back(vrow(FMT_FLOAT64, 0, 64'h01234567_89ABCDEF, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_RSVD6, 0, 64'h00000000_00000000, 0, 0, 0, 0));
		vecs.push_back(vrow(FMT_RSVD7, 1, 64'h80000000_7FFFFFFF, 1, 0, 0, 0));

		// directed rows, no idling
		foreach (vecs[i]) begin
			if (vecs[i].fmt != cur_fmt || vecs[i].le != cur_le) begin
				in_valid <= 1'b0;
				set_format(vecs[i].fmt, vecs[i].le);
			end
			typed = '{packed_bytes: vecs[i].bytes, byte_count: vecs[i].count,
				last_of_block: vecs[i].eob};
			send_beat(vecs[i].bits, vecs[i].eob, vecs[i].known, typed);
		end

		// random samples over four phases of input idling and output stalls
		for (int ph = 0; ph < 4; ph++) begin
			in_valid <= 1'b0;
			drain();
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 34) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 73 : 34) : 0;
			for (int seg = 0; seg < 3; seg++) begin
				in_valid <= 1'b0;
				set_format(fmt_t'($urandom_range(7)), 1'($urandom));
				for (int k = 0; k < 46; k++)
					send_beat(random_sample(), 1'($urandom_range(3) == 0), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
